[rtl/core/sprp2_pkg.sv]
// ----------------------------------------------------------------------------
// sprp2_pkg
// shared widths, types and the modular add used by the base-two prp tester
// ----------------------------------------------------------------------------
package sprp2_pkg;

  localparam int NUM_W = 63;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // status of the serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  // (a + b) mod m for a, b < m
  function automatic num_t add_mod(num_t a, num_t b, num_t m);
    logic [NUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[NUM_W-1:0];
  endfunction

endpackage

[rtl/core/sprp2_mulmod.sv]
// ----------------------------------------------------------------------------
// sprp2_mulmod
// bit-serial shift-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module sprp2_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sprp2_pkg::num_t     op_a,
  input  sprp2_pkg::num_t     op_b,
  input  sprp2_pkg::num_t     modulus,
  output sprp2_pkg::num_t     product,
  output sprp2_pkg::mm_stat_t stat
);
  import sprp2_pkg::*;

  logic busy_r, busy_nxt;
  num_t acc_r, acc_nxt;
  num_t addend_r, addend_nxt;
  num_t mplr_r, mplr_nxt;
  logic last;

  // multiplier shifted out: accumulator holds the product
  assign last = (mplr_r == '0);

  always_comb begin
    busy_nxt   = busy_r;
    acc_nxt    = acc_r;
    addend_nxt = addend_r;
    mplr_nxt   = mplr_r;
    if (start) begin
      busy_nxt   = 1'b1;
      acc_nxt    = '0;
      addend_nxt = op_a;
      mplr_nxt   = op_b;
    end else if (busy_r) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        if (mplr_r[0]) begin
          acc_nxt = add_mod(acc_r, addend_r, modulus);
        end
        addend_nxt = add_mod(addend_r, addend_r, modulus);
        mplr_nxt   = mplr_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r    <= acc_nxt;
    addend_r <= addend_nxt;
    mplr_r   <= mplr_nxt;
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = busy_r & last;

endmodule

[rtl/core/strong_probable_prime_base_two.sv]
// ----------------------------------------------------------------------------
// strong_probable_prime_base_two
// miller-rabin strong probable prime test with the single witness two
// ----------------------------------------------------------------------------
// One 63-bit candidate in, one verdict bit out. Zero, one and all even
// numbers, two included, are settled in the accept cycle and go straight
// to the final state that hands the verdict over. For an odd candidate p
// the block strips trailing zeros of p-1 one bit per cycle, then forms
// 2^d mod p left to right over all 63 exponent bits: each bit is one
// modular squaring plus an optional doubling, then up to r-1 more
// squarings. Every squaring goes through a bit-serial shift-add
// multiplier, the one multiplier that all squarings share. The verdict
// sits in an output register; a new item is accepted while it waits to
// be taken.
// ----------------------------------------------------------------------------
module strong_probable_prime_base_two (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sprp2_pkg::NUM_W-1:0]  in_candidate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_probable_prime
);
  import sprp2_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SPLIT    = 8'b0000_0010,
    ST_EXP_GO   = 8'b0000_0100,
    ST_EXP_WAIT = 8'b0000_1000,
    ST_CHK      = 8'b0001_0000,
    ST_SQ_GO    = 8'b0010_0000,
    ST_SQ_WAIT  = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_t;

  localparam num_t NUM_ONE = num_t'(1);
  localparam cnt_t CNT_ONE = cnt_t'(1);

  state_t   state_r, state_nxt;
  num_t     p_r, p_nxt;          // modulus
  num_t     pm1_r, pm1_nxt;      // p - 1
  num_t     d_r, d_nxt;          // odd part, then exponent shift register
  num_t     x_r, x_nxt;          // running power of two
  cnt_t     r_r, r_nxt;          // trailing zero count of p - 1
  cnt_t     cnt_r, cnt_nxt;      // exponent bits or squarings left
  logic     verdict_r, verdict_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     out_bit_r, out_bit_nxt;
  logic     in_acc;
  logic     mm_start;
  num_t     mm_prod;
  mm_stat_t mm_stat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;

  // the multiplier always squares x
  sprp2_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (x_r),
    .op_b    (x_r),
    .modulus (p_r),
    .product (mm_prod),
    .stat    (mm_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    pm1_nxt       = pm1_r;
    d_nxt         = d_r;
    x_nxt         = x_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    mm_start      = 1'b0;

    // result register drains independently of the datapath
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          p_nxt   = in_candidate;
          pm1_nxt = in_candidate - NUM_ONE;
          d_nxt   = in_candidate - NUM_ONE;
          r_nxt   = '0;
          if (in_candidate[NUM_W-1:1] == '0) begin
            // zero or one
            verdict_nxt = 1'b0;
            state_nxt   = ST_FIN;
          end else if (!in_candidate[0]) begin
            // two passes, any other even number fails
            verdict_nxt = (in_candidate[NUM_W-1:2] == '0);
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        // strip one trailing zero per cycle
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          r_nxt = r_r + CNT_ONE;
        end else begin
          x_nxt     = NUM_ONE;
          cnt_nxt   = cnt_t'(NUM_W);
          state_nxt = ST_EXP_GO;
        end
      end
      ST_EXP_GO: begin
        if (cnt_r == '0) begin
          state_nxt = ST_CHK;
        end else begin
          mm_start  = 1'b1;
          state_nxt = ST_EXP_WAIT;
        end
      end
      ST_EXP_WAIT: begin
        if (mm_stat.done) begin
          // square, then double when the exponent bit is set
          if (d_r[NUM_W-1]) begin
            x_nxt = add_mod(mm_prod, mm_prod, p_r);
          end else begin
            x_nxt = mm_prod;
          end
          d_nxt     = d_r << 1;
          cnt_nxt   = cnt_r - CNT_ONE;
          state_nxt = ST_EXP_GO;
        end
      end
      ST_CHK: begin
        if (x_r == NUM_ONE || x_r == pm1_r) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          cnt_nxt   = r_r - CNT_ONE;
          state_nxt = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        if (cnt_r == '0) begin
          // squarings ran out
          verdict_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end else begin
          mm_start  = 1'b1;
          state_nxt = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (mm_stat.done) begin
          x_nxt = mm_prod;
          if (mm_prod == pm1_r) begin
            verdict_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end else if (mm_prod == NUM_ONE) begin
            // nontrivial square root of one
            verdict_nxt = 1'b0;
            state_nxt   = ST_FIN;
          end else begin
            cnt_nxt   = cnt_r - CNT_ONE;
            state_nxt = ST_SQ_GO;
          end
        end
      end
      ST_FIN: begin
        // hand the verdict over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = verdict_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r       <= p_nxt;
    pm1_r     <= pm1_nxt;
    d_r       <= d_nxt;
    x_r       <= x_nxt;
    r_r       <= r_nxt;
    cnt_r     <= cnt_nxt;
    verdict_r <= verdict_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_is_probable_prime = out_bit_r;

`ifndef SYNTHESIS
  // multiplier is idle whenever a new item may enter
  a_idle_mm: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mm_stat.busy)
    else $error("multiplier busy while accepting an item");

  // multiplier completes only while the sequencer waits on it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> (state_r == ST_EXP_WAIT || state_r == ST_SQ_WAIT))
    else $error("multiplier done outside a wait state");

  // running power stays reduced below the modulus
  a_x_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK || state_r == ST_SQ_GO) |-> (x_r < p_r))
    else $error("running power not reduced");

  // an accepted item always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted item did not start");
`endif

endmodule
